/* design/plu_pkg.sv */
`timescale 1ns / 1ps

package plu_pkg;

	localparam int COMP_W     = 16;
	localparam int ROOT_W     = 24;
	localparam int QUOT_W     = 15;
	localparam int NORM_SHIFT = 23;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	// squares, sum, one stage per root bit, divider set-up, one per quotient bit, output
	localparam int NORM_LAT       = 2 + ROOT_W + 1 + QUOT_W + 1;
	// six stages before the power chain, two after it
	localparam int SHADE_BASE_LAT = 8;

	localparam logic [CFG_IDX_W-1:0] REG_AMBIENT_LIGHT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POINT_LIGHT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIGHT_DIR     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_AMBIENT_COEFF = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DIFFUSE_COEFF = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SPECULAR_COEFF = 3'd5;

	// element 0 is x, 1 is y, 2 is z
	typedef logic [2:0][COMP_W-1:0] vec3_t;
	// element 0 is red, 1 green, 2 blue
	typedef logic [2:0][7:0]  rgb3_t;
	typedef logic [2:0][23:0] coef3_t;

	// arithmetic shift right rounding toward zero
	function automatic logic signed [63:0] shr_tz(input logic signed [63:0] v,
		input logic [5:0] sh);
		logic signed [63:0] bias;
		bias = (64'sd1 <<< sh) - 64'sd1;
		if (v < 0) begin
			shr_tz = (v + bias) >>> sh;
		end else begin
			shr_tz = v >>> sh;
		end
	endfunction

endpackage

/* design/plu_norm.sv */
`timescale 1ns / 1ps

module plu_norm
	import plu_pkg::*;
(
	input  logic  clk,
	input  logic  en,
	input  vec3_t vec,
	output vec3_t unit_vec
);

	localparam int DVD_W = COMP_W + 1 + NORM_SHIFT;

	// squares and their sum
	vec3_t            c_s1;
	logic [2:0][31:0] sq_s1;
	vec3_t            c_s2;
	logic [31:0]      sum_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1 <= vec;
			for (int i = 0; i < 3; i++) begin
				sq_s1[i] <= 32'($signed(vec[i])) * 32'($signed(vec[i]));
			end
			c_s2   <= c_s1;
			sum_s2 <= sq_s1[0] + sq_s1[1] + sq_s1[2];
		end
	end

	// square root of sum * 2^16, one result bit per stage
	logic [ROOT_W+1:0] rem_s  [1:ROOT_W-1];
	logic [31:0]       rad_s  [1:ROOT_W-1];
	logic [ROOT_W-1:0] root_s [1:ROOT_W];
	vec3_t             cq_s   [1:ROOT_W];

	for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
		localparam int K = ROOT_W - 1 - j;
		logic [ROOT_W+1:0] rem_in;
		logic [31:0]       rad_in;
		logic [ROOT_W-1:0] root_in;
		vec3_t             c_in;
		logic [47:0]       xr;
		logic [ROOT_W+3:0] trial_rem;
		logic [ROOT_W+3:0] trial_div;
		logic              ge;
		logic [ROOT_W+1:0] rem_nx;
		logic [ROOT_W-1:0] root_nx;

		if (j == 0) begin : g_first
			assign rem_in  = '0;
			assign rad_in  = sum_s2;
			assign root_in = '0;
			assign c_in    = c_s2;
		end else begin : g_next
			assign rem_in  = rem_s[j];
			assign rad_in  = rad_s[j];
			assign root_in = root_s[j];
			assign c_in    = cq_s[j];
		end

		assign xr        = {rad_in, 16'b0};
		assign trial_rem = {rem_in, xr[2*K+1 -: 2]};
		assign trial_div = (ROOT_W+4)'({root_in, 2'b01});
		assign ge        = trial_rem >= trial_div;
		assign rem_nx    = ge ? (ROOT_W+2)'(trial_rem - trial_div) : (ROOT_W+2)'(trial_rem);
		assign root_nx   = {root_in[ROOT_W-2:0], ge};

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[j+1] <= root_nx;
				cq_s[j+1]   <= c_in;
			end
		end

		if (j < ROOT_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[j+1] <= rem_nx;
					rad_s[j+1] <= rad_in;
				end
			end
		end
	end

	// restoring divide |c| * 2^23 / m, saturating at the Q1.15 maximum
	logic [2:0][DVD_W-1:0] dv_rem_s  [0:QUOT_W-1];
	logic [ROOT_W-1:0]     dv_m_s    [0:QUOT_W-1];
	logic [2:0][QUOT_W-1:0] dv_q_s   [0:QUOT_W];
	logic [2:0]            dv_ovf_s  [0:QUOT_W];
	logic [2:0]            dv_neg_s  [0:QUOT_W];
	logic                  dv_zero_s [0:QUOT_W];

	logic [2:0][COMP_W:0]  mag;
	logic [2:0][DVD_W-1:0] dvd;
	logic [DVD_W-1:0]      lim;

	always_comb begin
		lim = {1'b0, root_s[ROOT_W], 15'b0};
		for (int i = 0; i < 3; i++) begin
			mag[i] = cq_s[ROOT_W][i][COMP_W-1] ?
				(COMP_W+1)'(-((COMP_W+1)'($signed(cq_s[ROOT_W][i])))) :
				{1'b0, cq_s[ROOT_W][i]};
			dvd[i] = {mag[i], NORM_SHIFT'(0)};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_m_s[0]    <= root_s[ROOT_W];
			dv_zero_s[0] <= root_s[ROOT_W] == '0;
			for (int i = 0; i < 3; i++) begin
				dv_rem_s[0][i] <= dvd[i];
				dv_ovf_s[0][i] <= dvd[i] >= lim;
				dv_neg_s[0][i] <= cq_s[ROOT_W][i][COMP_W-1];
				dv_q_s[0][i]   <= '0;
			end
		end
	end

	for (genvar t = 1; t <= QUOT_W; t++) begin : g_div
		localparam int B = QUOT_W - t;
		logic [DVD_W-1:0]       dv;
		logic [2:0]             ge;
		logic [2:0][DVD_W-1:0]  rem_nx;
		logic [2:0][QUOT_W-1:0] q_nx;

		always_comb begin
			dv = DVD_W'(dv_m_s[t-1]) << B;
			for (int i = 0; i < 3; i++) begin
				ge[i]     = dv_rem_s[t-1][i] >= dv;
				rem_nx[i] = ge[i] ? dv_rem_s[t-1][i] - dv : dv_rem_s[t-1][i];
				q_nx[i]   = dv_q_s[t-1][i] | (QUOT_W'(ge[i]) << B);
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_q_s[t]    <= q_nx;
				dv_ovf_s[t]  <= dv_ovf_s[t-1];
				dv_neg_s[t]  <= dv_neg_s[t-1];
				dv_zero_s[t] <= dv_zero_s[t-1];
			end
		end

		if (t < QUOT_W) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					dv_rem_s[t] <= rem_nx;
					dv_m_s[t]   <= dv_m_s[t-1];
				end
			end
		end
	end

	logic [2:0][COMP_W-1:0] mag_o;
	vec3_t                  unit_s;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (dv_zero_s[QUOT_W]) begin
				mag_o[i] = '0;
			end else if (dv_ovf_s[QUOT_W][i]) begin
				mag_o[i] = {1'b0, {QUOT_W{1'b1}}};
			end else begin
				mag_o[i] = {1'b0, dv_q_s[QUOT_W][i]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				unit_s[i] <= dv_neg_s[QUOT_W][i] ? COMP_W'(-mag_o[i]) : mag_o[i];
			end
		end
	end

	assign unit_vec = unit_s;

endmodule

/* design/plu_shade.sv */
`timescale 1ns / 1ps

module plu_shade
	import plu_pkg::*;
#(
	parameter int EXP = 16
)(
	input  logic   clk,
	input  logic   en,
	input  vec3_t  n_vec,
	input  vec3_t  v_vec,
	input  vec3_t  l_vec,
	input  rgb3_t  amb_term,
	input  coef3_t lckd,
	input  coef3_t lcks,
	output rgb3_t  rgb
);

	localparam logic signed [16:0] PW_ONE = 17'sd32768;

	// N.L products
	vec3_t            n_s1, v_s1, l_s1;
	logic [2:0][31:0] pnl_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1 <= n_vec;
			v_s1 <= v_vec;
			l_s1 <= l_vec;
			for (int i = 0; i < 3; i++) begin
				pnl_s1[i] <= 32'($signed(n_vec[i])) * 32'($signed(l_vec[i]));
			end
		end
	end

	// N.L in Q.15 and the reflection scale
	logic signed [33:0] nl_sum;
	logic signed [18:0] ndl_c;
	vec3_t              n_s2, v_s2, l_s2;
	logic signed [18:0] ndl_s2;
	logic [19:0]        cons_s2;

	assign nl_sum = 34'($signed(pnl_s1[0])) + 34'($signed(pnl_s1[1]))
		+ 34'($signed(pnl_s1[2]));
	assign ndl_c  = 19'(shr_tz(64'(nl_sum), 6'd15));

	always_ff @(posedge clk) begin
		if (en) begin
			n_s2    <= n_s1;
			v_s2    <= v_s1;
			l_s2    <= l_s1;
			ndl_s2  <= ndl_c;
			cons_s2 <= (ndl_c > 0) ? {ndl_c, 1'b0} : '0;
		end
	end

	// R = cons * N - L
	logic [2:0][36:0]   pr_s3;
	vec3_t              v_s3, l_s3;
	logic signed [18:0] ndl_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pr_s3[i] <= 37'($signed({1'b0, cons_s2})) * 37'($signed(n_s2[i]));
			end
			v_s3   <= v_s2;
			l_s3   <= l_s2;
			ndl_s3 <= ndl_s2;
		end
	end

	logic [2:0][20:0]   r_s4;
	vec3_t              v_s4;
	logic signed [18:0] ndl_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				r_s4[i] <= 21'(shr_tz(64'($signed(pr_s3[i])), 6'd15)
					- 64'($signed(l_s3[i])));
			end
			v_s4   <= v_s3;
			ndl_s4 <= ndl_s3;
		end
	end

	// R.V
	logic [2:0][36:0]   prv_s5;
	logic signed [18:0] ndl_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				prv_s5[i] <= 37'($signed(r_s4[i])) * 37'($signed(v_s4[i]));
			end
			ndl_s5 <= ndl_s4;
		end
	end

	logic signed [38:0] rv_sum;
	logic signed [63:0] rv_q15;
	logic signed [16:0] rdv_c;
	logic signed [16:0] rdv_p [0:EXP-1];
	logic signed [18:0] ndl_p [0:EXP];
	logic signed [16:0] pw_s  [1:EXP];

	always_comb begin
		rv_sum = 39'($signed(prv_s5[0])) + 39'($signed(prv_s5[1]))
			+ 39'($signed(prv_s5[2]));
		rv_q15 = shr_tz(64'(rv_sum), 6'd15);
		if (rv_q15 > 64'sd32768) begin
			rdv_c = PW_ONE;
		end else if (rv_q15 < -64'sd32768) begin
			rdv_c = -PW_ONE;
		end else begin
			rdv_c = 17'(rv_q15);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rdv_p[0] <= rdv_c;
			ndl_p[0] <= ndl_s5;
		end
	end

	// power chain, one multiply per stage
	for (genvar p = 0; p < EXP; p++) begin : g_pow
		logic signed [16:0] pw_in;
		logic signed [33:0] prod;

		if (p == 0) begin : g_first
			assign pw_in = PW_ONE;
		end else begin : g_next
			assign pw_in = pw_s[p];
		end

		assign prod = 34'(pw_in) * 34'(rdv_p[p]);

		always_ff @(posedge clk) begin
			if (en) begin
				pw_s[p+1]  <= 17'(shr_tz(64'(prod), 6'd15));
				ndl_p[p+1] <= ndl_p[p];
			end
		end

		if (p + 1 < EXP) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rdv_p[p+1] <= rdv_p[p];
				end
			end
		end
	end

	// stage numbers below count the fixed stages only
	logic [2:0][43:0] dp_s7;
	logic [2:0][41:0] sp_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				dp_s7[c] <= 44'($signed({1'b0, lckd[c]})) * 44'(ndl_p[EXP]);
				sp_s7[c] <= 42'($signed({1'b0, lcks[c]})) * 42'(pw_s[EXP]);
			end
		end
	end

	logic signed [13:0] tot [0:2];
	rgb3_t              rgb_c;
	rgb3_t              rgb_s8;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			tot[c] = 14'($signed({6'b0, amb_term[c]}))
				+ 14'(shr_tz(64'($signed(dp_s7[c])), 6'd31))
				+ 14'(shr_tz(64'($signed(sp_s7[c])), 6'd31));
			if (tot[c] < 0) begin
				rgb_c[c] = '0;
			end else if (tot[c] > 14'sd255) begin
				rgb_c[c] = 8'hff;
			end else begin
				rgb_c[c] = tot[c][7:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rgb_s8 <= rgb_c;
		end
	end

	assign rgb = rgb_s8;

endmodule

/* design/phong_lighting_unit.sv */
// Phong shading unit: one lit RGB triple per surface sample.
// Input channel (in_valid/in_ready) carries a normal and a view vector, each
// three signed 16-bit components; output channel (out_valid/out_ready)
// returns red, green and blue, each saturated to 0..255.
// Lights and reflection coefficients sit in six write-only registers
// (cfg_wr_en, cfg_index, cfg_data); write them only with the unit empty.
// A write takes effect for a transaction accepted on the next cycle on.
// Normal, view and light direction each go through their own normaliser:
// a square root pipeline with one root bit per stage and a divider with one
// quotient bit per stage, 43 stages in all. Shading adds 8 stages plus one
// multiply stage per unit of SPECULAR_EXPONENT.
// Throughput: one transaction per cycle while in_ready is high.
// A result waiting on out_ready is held in the output register and one more
// lands in a skid register; only then does the pipeline stall and in_ready
// drop, so nothing is lost or repeated.
// Reset clears all valid flags and configuration registers to zero.
`timescale 1ns / 1ps

module phong_lighting_unit
	import plu_pkg::*;
#(
	parameter int SPECULAR_EXPONENT = 16
)(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic signed [15:0]    normal_x,
	input  logic signed [15:0]    normal_y,
	input  logic signed [15:0]    normal_z,
	input  logic signed [15:0]    view_x,
	input  logic signed [15:0]    view_y,
	input  logic signed [15:0]    view_z,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            red,
	output logic [7:0]            green,
	output logic [7:0]            blue,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int PIPE_DEPTH = NORM_LAT + SHADE_BASE_LAT + SPECULAR_EXPONENT;

	logic [23:0] ambient_light_q;
	logic [23:0] point_light_q;
	logic [47:0] light_dir_q;
	logic [47:0] ambient_coeff_q;
	logic [47:0] diffuse_coeff_q;
	logic [47:0] specular_coeff_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ambient_light_q  <= '0;
			point_light_q    <= '0;
			light_dir_q      <= '0;
			ambient_coeff_q  <= '0;
			diffuse_coeff_q  <= '0;
			specular_coeff_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_AMBIENT_LIGHT:  ambient_light_q  <= cfg_data[23:0];
				REG_POINT_LIGHT:    point_light_q    <= cfg_data[23:0];
				REG_LIGHT_DIR:      light_dir_q      <= cfg_data;
				REG_AMBIENT_COEFF:  ambient_coeff_q  <= cfg_data;
				REG_DIFFUSE_COEFF:  diffuse_coeff_q  <= cfg_data;
				REG_SPECULAR_COEFF: specular_coeff_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// per-channel terms that depend on configuration only
	rgb3_t  amb_term_q;
	coef3_t lckd_q;
	coef3_t lcks_q;

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			amb_term_q[c] <= 8'((24'(ambient_light_q[16-8*c +: 8])
				* 24'(ambient_coeff_q[32-16*c +: 16])) >> 16);
			lckd_q[c] <= 24'(point_light_q[16-8*c +: 8]) * 24'(diffuse_coeff_q[32-16*c +: 16]);
			lcks_q[c] <= 24'(point_light_q[16-8*c +: 8]) * 24'(specular_coeff_q[32-16*c +: 16]);
		end
	end

	logic adv;
	logic sk_v_q;
	logic out_v_q;
	logic [PIPE_DEPTH-1:0] vld_q;

	assign adv      = !sk_v_q;
	assign in_ready = adv;

	vec3_t n_in, v_in, l_in;
	vec3_t n_unit, v_unit, l_unit;
	rgb3_t pipe_rgb;

	assign n_in[0] = normal_x;
	assign n_in[1] = normal_y;
	assign n_in[2] = normal_z;
	assign v_in[0] = view_x;
	assign v_in[1] = view_y;
	assign v_in[2] = view_z;
	assign l_in[0] = light_dir_q[47:32];
	assign l_in[1] = light_dir_q[31:16];
	assign l_in[2] = light_dir_q[15:0];

	plu_norm u_norm_n (
		.clk      (clk),
		.en       (adv),
		.vec      (n_in),
		.unit_vec (n_unit)
	);

	plu_norm u_norm_v (
		.clk      (clk),
		.en       (adv),
		.vec      (v_in),
		.unit_vec (v_unit)
	);

	plu_norm u_norm_l (
		.clk      (clk),
		.en       (adv),
		.vec      (l_in),
		.unit_vec (l_unit)
	);

	plu_shade #(
		.EXP (SPECULAR_EXPONENT)
	) u_shade (
		.clk      (clk),
		.en       (adv),
		.n_vec    (n_unit),
		.v_vec    (v_unit),
		.l_vec    (l_unit),
		.amb_term (amb_term_q),
		.lckd     (lckd_q),
		.lcks     (lcks_q),
		.rgb      (pipe_rgb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[PIPE_DEPTH-2:0], in_valid};
		end
	end

	// output register plus skid register
	rgb3_t out_rgb_q;
	rgb3_t sk_rgb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sk_v_q  <= 1'b0;
		end else if (sk_v_q) begin
			if (out_ready) begin
				sk_v_q <= 1'b0;
			end
		end else if (out_v_q && !out_ready) begin
			if (vld_q[PIPE_DEPTH-1]) begin
				sk_v_q <= 1'b1;
			end
		end else begin
			out_v_q <= vld_q[PIPE_DEPTH-1];
		end
	end

	always_ff @(posedge clk) begin
		if (sk_v_q) begin
			if (out_ready) begin
				out_rgb_q <= sk_rgb_q;
			end
		end else if (out_v_q && !out_ready) begin
			sk_rgb_q <= pipe_rgb;
		end else begin
			out_rgb_q <= pipe_rgb;
		end
	end

	assign out_valid = out_v_q;
	assign red       = out_rgb_q[0];
	assign green     = out_rgb_q[1];
	assign blue      = out_rgb_q[2];

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		sk_v_q |-> out_v_q)
		else $error("skid register full while output register empty");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		sk_v_q && out_ready |=> out_v_q && out_rgb_q == $past(sk_rgb_q))
		else $error("skid transaction not moved to the output register");

	a_pipe_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		sk_v_q |=> vld_q == $past(vld_q))
		else $error("pipeline moved while the skid register was full");

endmodule
